### hw/rtl/hdbrt_pkg.sv
// Shared constants and types for the half-duplex bus request tracker.
`timescale 1ns / 1ps
package hdbrt_pkg;

  localparam int QUEUE_SLOTS   = 4;
  localparam int PENDING_SLOTS = 8;
  localparam int FRAME_MAX     = 1023;
  localparam int QW            = $clog2(QUEUE_SLOTS + 1);
  localparam int PW            = $clog2(PENDING_SLOTS + 1);
  localparam int QIW           = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int PIW           = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int FIFO_DEPTH    = 2;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ENQUEUE = 2'd1;
  localparam logic [1:0] OP_RECEIVE = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [1:0] MTYPE_TEXT   = 2'd1;
  localparam logic [1:0] MTYPE_BINARY = 2'd2;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_TURN_TX = 3'd1;
  localparam logic [2:0] PH_TX      = 3'd2;
  localparam logic [2:0] PH_TURN_RX = 3'd3;
  localparam logic [2:0] PH_RX      = 3'd4;

  localparam logic [2:0] SLOT_NONE = 3'd7;

  localparam logic [1:0] KIND_REQUEST  = 2'd1;
  localparam logic [1:0] KIND_RESPONSE = 2'd2;
  localparam logic [1:0] KIND_EVENT    = 2'd3;

  localparam logic [2:0] REG_TURN_TX  = 3'd0;
  localparam logic [2:0] REG_TURN_RX  = 3'd1;
  localparam logic [2:0] REG_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_HALF_DUP = 3'd3;
  localparam logic [2:0] REG_FRAME_LIM = 3'd4;

  // Classified command passed from the front end to the sequencer.
  typedef struct packed {
    logic [1:0]  op;
    logic        enq_ok;
    logic [7:0]  client;
    logic [1:0]  mtype;
    logic [9:0]  length;
    logic        track;
    logic [31:0] request;
    logic [31:0] match;
  } cmd_t;

  // True once now has reached deadline, with 32-bit wrapping.
  function automatic logic time_reached(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] diff;
    diff = now - dl;
    return ~diff[31];
  endfunction

endpackage

### hw/rtl/hdbrt_front.sv
// Front end: takes commands, classifies them and holds them in a short queue.
`timescale 1ns / 1ps
module hdbrt_front import hdbrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  operation,
  input  logic [7:0]  client_num,
  input  logic [1:0]  message_type,
  input  logic [9:0]  frame_length,
  input  logic [1:0]  msg_kind,
  input  logic        wants_response,
  input  logic [31:0] request_number,
  input  logic [31:0] reply_number,
  input  logic        meta_valid,
  input  logic [9:0]  frame_size_limit,
  input  logic        take,
  output logic        full,
  output logic        empty,
  output cmd_t        head
);

  cmd_t       cmd_in;
  cmd_t       fifo [FIFO_DEPTH];
  logic [0:0] wptr, rptr;
  logic [1:0] count;
  logic [1:0] kind;
  logic [31:0] reqn, repn;
  logic push;

  assign full  = (count == 2'(FIFO_DEPTH));
  assign empty = (count == 2'd0);
  assign push  = start && !full;
  assign head  = fifo[rptr];

  // Classification of the incoming command.
  always_comb begin
    kind = meta_valid ? msg_kind : 2'd0;
    reqn = meta_valid ? request_number : 32'd0;
    repn = meta_valid ? reply_number : 32'd0;
    cmd_in.op      = operation;
    cmd_in.client  = client_num;
    cmd_in.mtype   = message_type;
    cmd_in.length  = frame_length;
    cmd_in.request = reqn;
    cmd_in.enq_ok  = (frame_length != 10'd0) && (frame_size_limit != 10'd0) &&
                     (frame_length <= frame_size_limit) &&
                     (32'(frame_length) <= 32'(FRAME_MAX)) &&
                     ((message_type == MTYPE_TEXT) || (message_type == MTYPE_BINARY));
    cmd_in.track   = (kind == KIND_REQUEST) && meta_valid && wants_response &&
                     (reqn != 32'd0);
    if (kind == KIND_RESPONSE) begin
      cmd_in.match = (repn != 32'd0) ? repn : reqn;
    end else if (kind == KIND_EVENT) begin
      cmd_in.match = repn;
    end else begin
      cmd_in.match = 32'd0;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= cmd_in;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (take) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + 2'(push) - 2'(take);
    end
  end

endmodule

### hw/rtl/hdbrt_back.sv
// Back end: sequencer that carries out commands over the slot queue and pending table.
`timescale 1ns / 1ps
module hdbrt_back import hdbrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  cmd_t        head,
  output logic        take,
  output logic        idle,
  input  logic [15:0] turnaround_tx_time,
  input  logic [15:0] turnaround_rx_time,
  input  logic [31:0] response_timeout,
  input  logic        half_duplex_mode,
  output logic        done,
  output logic        accepted,
  output logic [2:0]  bus_phase,
  output logic        tx_done,
  output logic [7:0]  tx_client,
  output logic [1:0]  tx_type,
  output logic [9:0]  tx_length,
  output logic [31:0] tx_request,
  output logic [3:0]  timeouts_now,
  output logic        pending_full_drop,
  output logic        completed,
  output logic [2:0]  queue_used,
  output logic [3:0]  pending_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  state;
  cmd_t        cur;
  logic [PIW-1:0] idx;

  logic [31:0] ms_clock, phase_since;
  logic [2:0]  phase, active_slot;
  logic [QUEUE_SLOTS-1:0]   slot_valid;
  logic [7:0]  slot_client [QUEUE_SLOTS];
  logic [1:0]  slot_type   [QUEUE_SLOTS];
  logic [9:0]  slot_len    [QUEUE_SLOTS];
  logic        slot_track  [QUEUE_SLOTS];
  logic [31:0] slot_req    [QUEUE_SLOTS];
  logic [PENDING_SLOTS-1:0] pend_valid;
  logic [31:0] pend_request  [PENDING_SLOTS];
  logic [31:0] pend_deadline [PENDING_SLOTS];
  logic [9:0]  last_length;

  // Scan results gathered one entry per cycle.
  logic        hit_found, free_found;
  logic [PIW-1:0] hit_idx, free_idx;
  logic [31:0] key;
  logic [3:0]  tmo;

  // Combinational slot search.
  logic        slot_free_found, slot_any;
  logic [2:0]  slot_free_idx, slot_first;
  logic [QW-1:0] qcount;
  logic [PW-1:0] pcount;
  logic        tx_ok;
  logic [QIW-1:0] as_sel, free_sel;

  assign idle = (state == S_IDLE);
  assign take = (state == S_IDLE) && !empty;
  assign as_sel   = active_slot[QIW-1:0];
  assign free_sel = slot_free_idx[QIW-1:0];
  assign tx_ok = (32'(active_slot) < 32'(QUEUE_SLOTS)) && slot_valid[as_sel];

  always_comb begin
    slot_free_found = 1'b0;
    slot_free_idx   = 3'd0;
    slot_any        = 1'b0;
    slot_first      = 3'd0;
    qcount          = '0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        slot_free_found = 1'b1;
        slot_free_idx   = 3'(i);
      end else begin
        slot_any   = 1'b1;
        slot_first = 3'(i);
      end
    end
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      qcount = qcount + QW'(slot_valid[i]);
    end
    pcount = '0;
    for (int i = 0; i < PENDING_SLOTS; i++) begin
      pcount = pcount + PW'(pend_valid[i]);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      ms_clock    <= '0;
      phase       <= PH_IDLE;
      phase_since <= '0;
      active_slot <= SLOT_NONE;
      slot_valid  <= '0;
      pend_valid  <= '0;
      last_length <= '0;
      idx         <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!empty) begin
            cur        <= head;
            idx        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            tmo        <= '0;
            tx_done    <= 1'b0;
            pending_full_drop <= 1'b0;
            completed  <= 1'b0;
            accepted   <= 1'b1;
            tx_client  <= '0;
            tx_type    <= '0;
            tx_request <= '0;
            if (head.op == OP_TICK) begin
              ms_clock <= ms_clock + 32'd1;
              key      <= tx_ok ? slot_req[as_sel] : 32'd0;
            end else begin
              key <= head.match;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // One pending entry per cycle: expiry on ticks, id match for lookups.
          if (cur.op == OP_TICK && pend_valid[idx] &&
              time_reached(ms_clock, pend_deadline[idx])) begin
            pend_valid[idx] <= 1'b0;
            tmo <= tmo + 4'd1;
          end else if (pend_valid[idx] && key != 32'd0 && pend_request[idx] == key &&
                       !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= idx;
          end
          if (!pend_valid[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end else if (cur.op == OP_TICK && pend_valid[idx] && !free_found &&
                       time_reached(ms_clock, pend_deadline[idx])) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (32'(idx) == 32'(PENDING_SLOTS - 1)) begin
            state <= S_EXEC;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EXEC: begin
          timeouts_now <= tmo;
          case (cur.op)
            OP_TICK: begin
              case (phase)
                PH_IDLE: begin
                  if (slot_any) begin
                    active_slot <= slot_first;
                    phase_since <= ms_clock;
                    phase <= half_duplex_mode ? PH_TURN_TX : PH_TX;
                  end
                end
                PH_TURN_TX: begin
                  if (time_reached(ms_clock, phase_since + 32'(turnaround_tx_time))) begin
                    phase <= PH_TX;
                    phase_since <= ms_clock;
                  end
                end
                PH_TX: begin
                  phase_since <= ms_clock;
                  if (!tx_ok) begin
                    phase <= PH_IDLE;
                    active_slot <= SLOT_NONE;
                  end else begin
                    tx_done     <= 1'b1;
                    tx_client   <= slot_client[as_sel];
                    tx_type     <= slot_type[as_sel];
                    tx_request  <= slot_req[as_sel];
                    last_length <= slot_len[as_sel];
                    if (slot_track[as_sel]) begin
                      if (hit_found) begin
                        pend_deadline[hit_idx] <= ms_clock + response_timeout;
                      end else if (free_found) begin
                        pend_valid[free_idx]    <= 1'b1;
                        pend_request[free_idx]  <= key;
                        pend_deadline[free_idx] <= ms_clock + response_timeout;
                      end else begin
                        pending_full_drop <= 1'b1;
                      end
                    end
                    slot_valid[as_sel] <= 1'b0;
                    phase <= half_duplex_mode ? PH_TURN_RX : PH_IDLE;
                    if (!half_duplex_mode) begin
                      active_slot <= SLOT_NONE;
                    end
                  end
                end
                PH_TURN_RX: begin
                  if (time_reached(ms_clock, phase_since + 32'(turnaround_rx_time))) begin
                    phase <= PH_IDLE;
                    phase_since <= ms_clock;
                    active_slot <= SLOT_NONE;
                  end
                end
                default: begin
                  if (time_reached(ms_clock, phase_since + 32'(turnaround_rx_time))) begin
                    phase <= PH_IDLE;
                    phase_since <= ms_clock;
                  end
                end
              endcase
            end
            OP_ENQUEUE: begin
              if (cur.enq_ok && slot_free_found) begin
                slot_valid[free_sel]  <= 1'b1;
                slot_client[free_sel] <= cur.client;
                slot_type[free_sel]   <= cur.mtype;
                slot_len[free_sel]    <= cur.length;
                slot_track[free_sel]  <= cur.track;
                slot_req[free_sel]    <= cur.request;
                if (phase == PH_IDLE) begin
                  // Lowest valid slot after the write.
                  active_slot <= (slot_any && slot_first < slot_free_idx) ? slot_first
                                                                          : slot_free_idx;
                  phase_since <= ms_clock;
                  phase <= half_duplex_mode ? PH_TURN_TX : PH_TX;
                end
              end else begin
                accepted <= 1'b0;
              end
            end
            OP_RECEIVE: begin
              phase <= PH_RX;
              phase_since <= ms_clock;
              if (hit_found) begin
                pend_valid[hit_idx] <= 1'b0;
                completed <= 1'b1;
              end
            end
            default: begin
            end
          endcase
          state <= S_DONE;
        end
        default: begin
          // Status after the item's updates.
          bus_phase     <= phase;
          tx_length     <= last_length;
          queue_used    <= 3'(qcount);
          pending_count <= 4'(pcount);
          done  <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/half_duplex_bus_request_tracker_core.sv
// Top level of the half-duplex bus request tracker.
`timescale 1ns / 1ps
// Usage:
// A command is taken when start is high and busy is low. operation selects a
// millisecond tick, an enqueue of a frame or a received frame. Commands are
// classified on entry and held in a two-entry queue; busy is high while that
// queue is full. The sequencer takes one command at a time and walks the
// eight-entry pending table one entry per cycle; it takes no further command
// until it has given the result of the current one. Each command gives exactly
// one result, shown for one cycle with done high. The receiver cannot stall;
// results are never held back. Configuration registers are written through
// cfg_write, cfg_index and cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce.
// Reset empties the queue, the transmit slots and the pending table, sets the
// bus idle, the clock to zero and the registers to their defaults.
module half_duplex_bus_request_tracker_core import hdbrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [7:0]  client_num,
  input  logic [1:0]  message_type,
  input  logic [9:0]  frame_length,
  input  logic [1:0]  msg_kind,
  input  logic        wants_response,
  input  logic [31:0] request_number,
  input  logic [31:0] reply_number,
  input  logic        meta_valid,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic        accepted,
  output logic [2:0]  bus_phase,
  output logic        tx_done,
  output logic [7:0]  tx_client,
  output logic [1:0]  tx_type,
  output logic [9:0]  tx_length,
  output logic [31:0] tx_request,
  output logic [3:0]  timeouts_now,
  output logic        pending_full_drop,
  output logic        completed,
  output logic [2:0]  queue_used,
  output logic [3:0]  pending_count
);

  logic [15:0] turnaround_tx_time, turnaround_rx_time;
  logic [31:0] response_timeout;
  logic        half_duplex_mode;
  logic [9:0]  frame_size_limit;
  logic        full, empty, take, back_idle;
  cmd_t        head;

  assign busy = full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      turnaround_tx_time <= 16'd2;
      turnaround_rx_time <= 16'd2;
      response_timeout   <= 32'd1000;
      half_duplex_mode   <= 1'b1;
      frame_size_limit   <= 10'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TURN_TX:   turnaround_tx_time <= cfg_data[15:0];
        REG_TURN_RX:   turnaround_rx_time <= cfg_data[15:0];
        REG_TIMEOUT:   response_timeout   <= cfg_data;
        REG_HALF_DUP:  half_duplex_mode   <= cfg_data[0];
        REG_FRAME_LIM: frame_size_limit   <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  hdbrt_front u_front (
    .clk, .rst, .start, .operation, .client_num, .message_type, .frame_length,
    .msg_kind, .wants_response, .request_number, .reply_number, .meta_valid,
    .frame_size_limit, .take, .full, .empty, .head
  );

  hdbrt_back u_back (
    .clk, .rst, .empty, .head, .take, .idle(back_idle),
    .turnaround_tx_time, .turnaround_rx_time, .response_timeout, .half_duplex_mode,
    .done, .accepted, .bus_phase, .tx_done, .tx_client, .tx_type, .tx_length,
    .tx_request, .timeouts_now, .pending_full_drop, .completed, .queue_used,
    .pending_count
  );

  // A result only follows a dequeued command.
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(back_idle)) else $error("result without a command");

  // The tx request and client fields are zero unless a frame finished.
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !tx_done) |-> (tx_request == 32'd0 && tx_client == 8'd0))
    else $error("tx fields set without tx_done");

  // Dequeue only happens when the sequencer is free.
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    take |-> (back_idle && !empty)) else $error("dequeue while busy");

endmodule

### test/half_duplex_bus_request_tracker_checker.sv
// Checker for the bus request tracker: tracks state, predicts each result and compares it.
`timescale 1ns / 1ps
module half_duplex_bus_request_tracker_checker import hdbrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic [7:0]  client_num,
  input  logic [1:0]  message_type,
  input  logic [9:0]  frame_length,
  input  logic [1:0]  msg_kind,
  input  logic        wants_response,
  input  logic [31:0] request_number,
  input  logic [31:0] reply_number,
  input  logic        meta_valid,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic        accepted,
  input  logic [2:0]  bus_phase,
  input  logic        tx_done,
  input  logic [7:0]  tx_client,
  input  logic [1:0]  tx_type,
  input  logic [9:0]  tx_length,
  input  logic [31:0] tx_request,
  input  logic [3:0]  timeouts_now,
  input  logic        pending_full_drop,
  input  logic        completed,
  input  logic [2:0]  queue_used,
  input  logic [3:0]  pending_count,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic        acc;
    logic [2:0]  ph;
    logic        txd;
    logic [7:0]  client;
    logic [1:0]  mtype;
    logic [9:0]  len;
    logic [31:0] req;
    logic [3:0]  tmo;
    logic        drop;
    logic        comp;
    logic [2:0]  qused;
    logic [3:0]  pused;
  } bus_result_t;

  typedef struct packed {
    logic [7:0]  client;
    logic [1:0]  mtype;
    logic [9:0]  len;
    logic [1:0]  kind;
    logic        wants;
    logic [31:0] req;
  } frame_slot_t;

  // Register copies.
  logic [15:0] turn_tx_ms, turn_rx_ms;
  logic [31:0] resp_timeout;
  logic        half_dup;
  logic [9:0]  frame_limit;

  // Sequencer state copies.
  logic [31:0] now_ms, phase_start;
  logic [2:0]  line_phase, cur_slot;
  logic        slot_busy [QUEUE_SLOTS];
  frame_slot_t slot_frame [QUEUE_SLOTS];
  logic        req_live [PENDING_SLOTS];
  logic [31:0] req_id [PENDING_SLOTS];
  logic [31:0] req_deadline [PENDING_SLOTS];
  logic [9:0]  last_len;
  int          mismatches = 0;

  bus_result_t expected_results[$];

  assign outstanding = expected_results.size();
  assign errors = mismatches;

  function automatic logic deadline_passed(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] diff;
    diff = now - dl;
    return !diff[31];
  endfunction

  function automatic int lookup_request(input logic [31:0] id);
    if (id == 32'd0) return -1;
    for (int i = 0; i < PENDING_SLOTS; i++)
      if (req_live[i] && req_id[i] == id) return i;
    return -1;
  endfunction

  task automatic launch_next();
    if (line_phase != PH_IDLE) return;
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      if (slot_busy[i]) begin
        cur_slot = 3'(i);
        phase_start = now_ms;
        line_phase = half_dup ? PH_TURN_TX : PH_TX;
        return;
      end
    end
  endtask

  // End of transmission: frees the slot and records the expected response.
  task automatic end_transmit(inout bus_result_t r);
    frame_slot_t f;
    int idx;
    logic tracked;
    if (cur_slot >= QUEUE_SLOTS || !slot_busy[cur_slot]) begin
      line_phase = PH_IDLE;
      phase_start = now_ms;
      cur_slot = SLOT_NONE;
      return;
    end
    f = slot_frame[cur_slot];
    r.txd = 1'b1;
    r.client = f.client;
    r.mtype = f.mtype;
    r.req = f.req;
    last_len = f.len;
    tracked = 1'b1;
    if (f.kind == KIND_REQUEST && f.wants && f.req != 32'd0) begin
      idx = lookup_request(f.req);
      if (idx >= 0) begin
        req_deadline[idx] = now_ms + resp_timeout;
      end else begin
        tracked = 1'b0;
        for (int i = 0; i < PENDING_SLOTS; i++) begin
          if (!req_live[i]) begin
            req_live[i] = 1'b1;
            req_id[i] = f.req;
            req_deadline[i] = now_ms + resp_timeout;
            tracked = 1'b1;
            break;
          end
        end
      end
    end
    r.drop = !tracked;
    slot_busy[cur_slot] = 1'b0;
    phase_start = now_ms;
    line_phase = half_dup ? PH_TURN_RX : PH_IDLE;
    if (!half_dup) cur_slot = SLOT_NONE;
  endtask

  // Works out the result of one command and advances the state copies.
  task automatic predict_command(output bus_result_t r);
    logic [1:0]  kind;
    logic        wants;
    logic [31:0] reqn, repn, match;
    int          idx, free_idx;
    kind  = meta_valid ? msg_kind : 2'd0;
    wants = meta_valid ? wants_response : 1'b0;
    reqn  = meta_valid ? request_number : 32'd0;
    repn  = meta_valid ? reply_number : 32'd0;
    r = '0;
    r.acc = 1'b1;
    case (operation)
      OP_TICK: begin
        now_ms = now_ms + 32'd1;
        for (int i = 0; i < PENDING_SLOTS; i++) begin
          if (req_live[i] && deadline_passed(now_ms, req_deadline[i])) begin
            req_live[i] = 1'b0;
            r.tmo = r.tmo + 4'd1;
          end
        end
        case (line_phase)
          PH_IDLE: launch_next();
          PH_TURN_TX: begin
            if (deadline_passed(now_ms, phase_start + 32'(turn_tx_ms))) begin
              line_phase = PH_TX;
              phase_start = now_ms;
            end
          end
          PH_TX: end_transmit(r);
          PH_TURN_RX: begin
            if (deadline_passed(now_ms, phase_start + 32'(turn_rx_ms))) begin
              line_phase = PH_IDLE;
              phase_start = now_ms;
              cur_slot = SLOT_NONE;
            end
          end
          default: begin
            if (deadline_passed(now_ms, phase_start + 32'(turn_rx_ms))) begin
              line_phase = PH_IDLE;
              phase_start = now_ms;
            end
          end
        endcase
      end
      OP_ENQUEUE: begin
        r.acc = 1'b0;
        free_idx = -1;
        if (frame_length != 10'd0 && frame_limit != 10'd0 && frame_length <= frame_limit &&
            (message_type == MTYPE_TEXT || message_type == MTYPE_BINARY)) begin
          for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (!slot_busy[i]) begin
              free_idx = i;
              break;
            end
          end
        end
        if (free_idx >= 0) begin
          slot_busy[free_idx] = 1'b1;
          slot_frame[free_idx] = '{client_num, message_type, frame_length, kind, wants, reqn};
          r.acc = 1'b1;
          launch_next();
        end
      end
      OP_RECEIVE: begin
        line_phase = PH_RX;
        phase_start = now_ms;
        match = '0;
        if (kind == KIND_RESPONSE) match = (repn != 32'd0) ? repn : reqn;
        else if (kind == KIND_EVENT) match = repn;
        idx = lookup_request(match);
        if (idx >= 0) begin
          req_live[idx] = 1'b0;
          r.comp = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < QUEUE_SLOTS; i++) if (slot_busy[i]) r.qused = r.qused + 3'd1;
    for (int i = 0; i < PENDING_SLOTS; i++) if (req_live[i]) r.pused = r.pused + 4'd1;
    r.ph = line_phase;
    r.len = last_len;
  endtask

  function automatic int field_diff(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (exp_v === act_v) return 0;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    bus_result_t r;
    if (rst) begin
      turn_tx_ms = 16'd2;
      turn_rx_ms = 16'd2;
      resp_timeout = 32'd1000;
      half_dup = 1'b1;
      frame_limit = 10'd256;
      now_ms = '0;
      phase_start = '0;
      line_phase = PH_IDLE;
      cur_slot = SLOT_NONE;
      last_len = '0;
      for (int i = 0; i < QUEUE_SLOTS; i++) slot_busy[i] = 1'b0;
      for (int i = 0; i < PENDING_SLOTS; i++) req_live[i] = 1'b0;
      expected_results.delete();
    end else begin
      // Compare a finished result with the oldest expectation.
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with no expectation waiting", $time);
          mismatches++;
        end else begin
          r = expected_results.pop_front();
          mismatches += field_diff("accepted", 32'(r.acc), 32'(accepted));
          mismatches += field_diff("bus_phase", 32'(r.ph), 32'(bus_phase));
          mismatches += field_diff("tx_done", 32'(r.txd), 32'(tx_done));
          mismatches += field_diff("tx_client", 32'(r.client), 32'(tx_client));
          mismatches += field_diff("tx_type", 32'(r.mtype), 32'(tx_type));
          mismatches += field_diff("tx_length", 32'(r.len), 32'(tx_length));
          mismatches += field_diff("tx_request", r.req, tx_request);
          mismatches += field_diff("timeouts_now", 32'(r.tmo), 32'(timeouts_now));
          mismatches += field_diff("pending_full_drop", 32'(r.drop),
                                   32'(pending_full_drop));
          mismatches += field_diff("completed", 32'(r.comp), 32'(completed));
          mismatches += field_diff("queue_used", 32'(r.qused), 32'(queue_used));
          mismatches += field_diff("pending_count", 32'(r.pused), 32'(pending_count));
        end
      end
      // Register writes.
      if (cfg_write) begin
        case (cfg_index)
          REG_TURN_TX:   turn_tx_ms = cfg_data[15:0];
          REG_TURN_RX:   turn_rx_ms = cfg_data[15:0];
          REG_TIMEOUT:   resp_timeout = cfg_data;
          REG_HALF_DUP:  half_dup = cfg_data[0];
          REG_FRAME_LIM: frame_limit = cfg_data[9:0];
          default: ;
        endcase
      end
      // Predict each command transfer.
      if (start && !busy) begin
        predict_command(r);
        expected_results.push_back(r);
      end
    end
  end

endmodule

### test/half_duplex_bus_request_tracker_core_test.sv
// Testbench top for the bus request tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module half_duplex_bus_request_tracker_core_test;
  import hdbrt_pkg::*;

  logic        clk, rst, start, busy;
  logic [1:0]  operation, message_type, msg_kind;
  logic [7:0]  client_num;
  logic [9:0]  frame_length;
  logic        wants_response, meta_valid;
  logic [31:0] request_number, reply_number;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        done, accepted, tx_done, pending_full_drop, completed;
  logic [2:0]  bus_phase, queue_used;
  logic [7:0]  tx_client;
  logic [1:0]  tx_type;
  logic [9:0]  tx_length;
  logic [31:0] tx_request;
  logic [3:0]  timeouts_now, pending_count;
  int          errors, outstanding;
  int          gap_pct;
  int          quiet_cycles;

  half_duplex_bus_request_tracker_core DUT (.*);
  half_duplex_bus_request_tracker_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Ends the run when neither a command nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Drives one command and waits for its transfer; start stays high afterwards unless a random gap drops it.
  task automatic issue(input logic [1:0] op, input logic [7:0] cl, input logic [1:0] mt,
                       input logic [9:0] len, input logic [1:0] kind, input logic wants,
                       input logic [31:0] reqn, input logic [31:0] repn, input logic meta);
    operation = op;
    client_num = cl;
    message_type = mt;
    frame_length = len;
    msg_kind = kind;
    wants_response = wants;
    request_number = reqn;
    reply_number = repn;
    meta_valid = meta;
    start = 1'b1;
    // busy only changes at rising edges, so it is stable at the falling edge.
    while (busy) @(negedge clk);
    @(negedge clk);
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Waits until every expected result has arrived, then lets the pipeline drain.
  task automatic drain();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_all(input logic [15:0] ttx, input logic [15:0] trx,
                         input logic [31:0] tmo, input logic hd, input logic [9:0] lim);
    write_reg(REG_TURN_TX, 32'(ttx));
    write_reg(REG_TURN_RX, 32'(trx));
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_HALF_DUP, 32'(hd));
    write_reg(REG_FRAME_LIM, 32'(lim));
  endtask

  // Mostly well-formed traffic over a small id pool, so that matches and refreshes happen.
  task automatic random_command();
    int          sel;
    logic [1:0]  op, mt, kind;
    logic [9:0]  len;
    logic [31:0] reqn, repn;
    sel = $urandom_range(99);
    op = (sel < 50) ? OP_TICK : (sel < 78) ? OP_ENQUEUE : (sel < 97) ? OP_RECEIVE : OP_NONE;
    mt = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
    len = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1, 300));
    reqn = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom;
    repn = ($urandom_range(9) < 7) ? $urandom_range(0, 12) : $urandom;
    if (op == OP_ENQUEUE) kind = ($urandom_range(3) != 0) ? KIND_REQUEST : 2'($urandom);
    else kind = ($urandom_range(3) != 0) ? 2'($urandom_range(2, 3)) : 2'($urandom);
    issue(op, 8'($urandom), mt, len, kind, ($urandom_range(4) != 0), reqn, repn,
          ($urandom_range(9) != 0));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_pct = 0;
    issue_defaults();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: rejects, tracking, refresh, matching, reception during transmit.
    issue(OP_ENQUEUE, 8'd0, 2'd1, 10'd1, KIND_REQUEST, 1'b1, 32'd1, 32'd0, 1'b1);
    issue(OP_ENQUEUE, 8'd255, 2'd2, 10'd256, KIND_REQUEST, 1'b1, 32'hFFFFFFFF, 32'd0, 1'b1);
    issue(OP_ENQUEUE, 8'd3, 2'd1, 10'd0, KIND_REQUEST, 1'b1, 32'd2, 32'd0, 1'b1);
    issue(OP_ENQUEUE, 8'd3, 2'd1, 10'd1023, KIND_REQUEST, 1'b1, 32'd2, 32'd0, 1'b1);
    issue(OP_ENQUEUE, 8'd3, 2'd0, 10'd5, KIND_REQUEST, 1'b1, 32'd2, 32'd0, 1'b1);
    issue(OP_ENQUEUE, 8'd3, 2'd3, 10'd5, KIND_REQUEST, 1'b1, 32'd2, 32'd0, 1'b1);
    issue(OP_ENQUEUE, 8'd4, 2'd1, 10'd7, KIND_REQUEST, 1'b1, 32'd1, 32'd0, 1'b1);
    issue(OP_ENQUEUE, 8'd5, 2'd2, 10'd9, KIND_EVENT, 1'b1, 32'd7, 32'd0, 1'b0);
    issue(OP_ENQUEUE, 8'd6, 2'd1, 10'd9, KIND_REQUEST, 1'b1, 32'd8, 32'd0, 1'b1);
    repeat (10) issue(OP_TICK, '0, '0, '0, '0, 1'b0, '0, '0, 1'b0);
    issue(OP_RECEIVE, '0, '0, '0, KIND_RESPONSE, 1'b0, 32'd1, 32'd0, 1'b1);
    issue(OP_RECEIVE, '0, '0, '0, KIND_EVENT, 1'b0, 32'd5, 32'hFFFFFFFF, 1'b1);
    issue(OP_RECEIVE, '0, '0, '0, KIND_RESPONSE, 1'b0, 32'd9, 32'd1, 1'b0);
    issue(OP_NONE, 8'hFF, 2'd3, 10'h3FF, 2'd3, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    drain();

    // Register extremes: every frame rejected, maximum turnarounds and timeout, then zero settings with random traffic.
    set_all(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 10'd0);
    issue(OP_ENQUEUE, 8'd1, 2'd1, 10'd1, KIND_REQUEST, 1'b1, 32'd3, 32'd0, 1'b1);
    repeat (4) issue(OP_TICK, '0, '0, '0, '0, 1'b0, '0, '0, 1'b0);
    drain();
    set_all(16'd0, 16'd0, 32'd0, 1'b0, 10'd1023);
    repeat (30) random_command();
    drain();

    // Random phases with different settings and sender gaps.
    for (int p = 0; p < 3; p++) begin
      gap_pct = (p == 0) ? 29 : (p == 1) ? 55 : 0;
      case (p)
        0: set_all(16'd1, 16'd0, 32'd20, 1'b1, 10'd1023);
        1: set_all(16'd3, 16'd5, 32'd200, 1'b0, 10'd300);
        default: set_all(16'd0, 16'd1, 32'd8, 1'b1, 10'd600);
      endcase
      repeat (620) random_command();
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  task automatic issue_defaults();
    operation = '0;
    client_num = '0;
    message_type = '0;
    frame_length = '0;
    msg_kind = '0;
    wants_response = 1'b0;
    request_number = '0;
    reply_number = '0;
    meta_valid = 1'b0;
  endtask

endmodule
